// File: design/gpot_pkg.sv
// Shared types and constants of the grid pose and occupancy tracker.
// No dependencies; gpot_pose and the top level refer to it by scoped names.
package gpot_pkg;

	typedef enum logic [1:0] {
		CMD_ROTATE = 2'd0,
		CMD_MOVE   = 2'd1,
		CMD_SONAR  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// Numbered clockwise from north.
	typedef enum logic [1:0] {
		HEAD_NORTH = 2'd0,
		HEAD_EAST  = 2'd1,
		HEAD_SOUTH = 2'd2,
		HEAD_WEST  = 2'd3
	} compass_t;

	typedef enum logic [1:0] {
		TURN_NONE  = 2'd0,
		TURN_RIGHT = 2'd1,
		TURN_LEFT  = 2'd2,
		TURN_BACK  = 2'd3
	} turn_t;

	typedef enum logic [1:0] {
		CELL_UNKNOWN  = 2'd0,
		CELL_EXPLORED = 2'd1,
		CELL_OCCUPIED = 2'd2,
		CELL_OUTSIDE  = 2'd3
	} cell_t;

	// Clockwise quarter steps from the current heading to the target.
	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_CW   = 2'd1;
	localparam logic [1:0] ROT_HALF = 2'd2;
	localparam logic [1:0] ROT_CCW  = 2'd3;

	localparam logic [8:0] THRESH_RESET = 9'd20;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] target_heading;
		logic [8:0] distance_cm;
		logic [7:0] query_x;
		logic [7:0] query_y;
	} item_t;

	typedef struct packed {
		logic [1:0] turn_kind;
		logic       moved;
		logic       obstacle;
		logic [1:0] cell_value;
		logic [5:0] cur_x;
		logic [5:0] cur_y;
		logic [1:0] cur_heading;
	} result_t;

endpackage

// File: design/gpot_if.sv
// Valid/ready channel interfaces for command requests and results.
// Standalone; field widths match the tracker's item and result formats.
interface gpot_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic [1:0]        target_heading;
	logic [8:0]        distance_cm;
	logic signed [7:0] query_x;
	logic signed [7:0] query_y;

	modport source (output valid, cmd, target_heading, distance_cm, query_x, query_y,
		input ready);
	modport sink (input valid, cmd, target_heading, distance_cm, query_x, query_y,
		output ready);
endinterface

interface gpot_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] turn_kind;
	logic       moved;
	logic       obstacle;
	logic [1:0] cell_value;
	logic [5:0] cur_x;
	logic [5:0] cur_y;
	logic [1:0] cur_heading;

	modport source (output valid, turn_kind, moved, obstacle, cell_value, cur_x, cur_y,
		cur_heading, input ready);
	modport sink (input valid, turn_kind, moved, obstacle, cell_value, cur_x, cur_y,
		cur_heading, output ready);
endinterface

// File: design/gpot_map.sv
// Occupancy map memory: one write port, one registered read port, clear sweep
// after reset and write-to-read forwarding. Uses nothing from gpot_pkg.
module gpot_map #(
	parameter int GRID_SIZE = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	output logic                                  busy,
	input  logic                                  rd_en,
	input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] rd_addr,
	output logic [1:0]                            rd_data,
	input  logic                                  wr_en,
	input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] wr_addr,
	input  logic [1:0]                            wr_data
);
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);

	logic [1:0]    mem [DEPTH];
	logic          clearing_q;
	logic [AW-1:0] clr_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [1:0]    mem_wd;
	logic [1:0]    rd_q;
	logic          fwd_q;
	logic [1:0]    fwd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign busy   = clearing_q;
	assign mem_we = clearing_q || wr_en;
	assign mem_wa = clearing_q ? clr_q : wr_addr;
	assign mem_wd = clearing_q ? 2'b00 : wr_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// A write landing on the same edge as the read bypasses the array.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_q      <= wr_en && (wr_addr == rd_addr);
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

// File: design/gpot_pose.sv
// Pose state, obstacle threshold and per-command step logic of the tracker.
// Depends on gpot_pkg for command, heading, turn and cell codes.
module gpot_pose #(
	parameter int GRID_SIZE = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [8:0]                            cfg_wdata,
	input  logic                                  go,
	input  gpot_pkg::item_t                       item,
	input  logic                                  q_in_grid,
	input  logic [1:0]                            rd_cell,
	output gpot_pkg::result_t                     res,
	output logic                                  wr_en,
	output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] wr_addr,
	output logic [1:0]                            wr_data
);
	localparam int PW = $clog2(GRID_SIZE);
	localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
	localparam logic [AW-1:0] GRID_W = AW'(GRID_SIZE);
	localparam logic [PW-1:0] LAST   = PW'(GRID_SIZE - 1);

	logic [8:0]         thresh_q;
	logic [PW-1:0]      col_q;
	logic [PW-1:0]      row_q;
	gpot_pkg::compass_t facing_q;

	logic [PW-1:0]      ahead_col;
	logic [PW-1:0]      ahead_row;
	logic               ahead_ok;
	logic [1:0]         diff;
	logic               step_move;
	logic               wr_req;
	gpot_pkg::cell_t    wr_cell;
	gpot_pkg::compass_t new_facing;
	gpot_pkg::turn_t    turn;
	gpot_pkg::cell_t    cell_code;
	logic               obst;
	logic [PW-1:0]      next_col;
	logic [PW-1:0]      next_row;

	always_comb begin
		ahead_col = col_q;
		ahead_row = row_q;
		ahead_ok  = 1'b0;
		unique case (facing_q)
			gpot_pkg::HEAD_NORTH: begin
				ahead_ok  = (row_q != '0);
				ahead_row = row_q - PW'(1);
			end
			gpot_pkg::HEAD_EAST: begin
				ahead_ok  = (col_q != LAST);
				ahead_col = col_q + PW'(1);
			end
			gpot_pkg::HEAD_SOUTH: begin
				ahead_ok  = (row_q != LAST);
				ahead_row = row_q + PW'(1);
			end
			gpot_pkg::HEAD_WEST: begin
				ahead_ok  = (col_q != '0);
				ahead_col = col_q - PW'(1);
			end
		endcase
	end

	assign diff = item.target_heading - 2'(facing_q);

	always_comb begin
		turn       = gpot_pkg::TURN_NONE;
		cell_code  = gpot_pkg::CELL_UNKNOWN;
		obst       = 1'b0;
		step_move  = 1'b0;
		wr_req     = 1'b0;
		wr_cell    = gpot_pkg::CELL_UNKNOWN;
		new_facing = facing_q;
		unique case (gpot_pkg::cmd_t'(item.cmd))
			gpot_pkg::CMD_ROTATE: begin
				new_facing = gpot_pkg::compass_t'(item.target_heading);
				unique case (diff)
					gpot_pkg::ROT_NONE: turn = gpot_pkg::TURN_NONE;
					gpot_pkg::ROT_CW:   turn = gpot_pkg::TURN_RIGHT;
					gpot_pkg::ROT_HALF: turn = gpot_pkg::TURN_BACK;
					gpot_pkg::ROT_CCW:  turn = gpot_pkg::TURN_LEFT;
				endcase
			end
			gpot_pkg::CMD_MOVE: begin
				if (ahead_ok) begin
					step_move = 1'b1;
					wr_req    = 1'b1;
					wr_cell   = gpot_pkg::CELL_EXPLORED;
				end
			end
			gpot_pkg::CMD_SONAR: begin
				if (item.distance_cm <= thresh_q) begin
					obst = 1'b1;
					// Off-grid obstacle still reports, but leaves the map alone.
					if (ahead_ok) begin
						wr_req  = 1'b1;
						wr_cell = gpot_pkg::CELL_OCCUPIED;
					end
				end
			end
			gpot_pkg::CMD_READ: begin
				cell_code = q_in_grid ? gpot_pkg::cell_t'(rd_cell) : gpot_pkg::CELL_OUTSIDE;
			end
		endcase
	end

	assign next_col = step_move ? ahead_col : col_q;
	assign next_row = step_move ? ahead_row : row_q;

	assign res.turn_kind   = 2'(turn);
	assign res.moved       = step_move;
	assign res.obstacle    = obst;
	assign res.cell_value  = 2'(cell_code);
	assign res.cur_x       = 6'(next_col);
	assign res.cur_y       = 6'(next_row);
	assign res.cur_heading = 2'(new_facing);

	assign wr_en   = go && wr_req;
	assign wr_addr = AW'(ahead_col) * GRID_W + AW'(ahead_row);
	assign wr_data = 2'(wr_cell);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= gpot_pkg::THRESH_RESET;
			col_q    <= '0;
			row_q    <= '0;
			facing_q <= gpot_pkg::HEAD_NORTH;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (go) begin
				col_q    <= next_col;
				row_q    <= next_row;
				facing_q <= new_facing;
			end
		end
	end

endmodule

// File: design/grid_pose_and_occupancy_tracker.sv
// Top level of the grid pose and occupancy tracker: handshakes, input and
// result registers. Depends on gpot_pkg, gpot_if, gpot_map and gpot_pose.

// Takes one command request per clock cycle unless the map sweep or a stalled result
// side holds it off, and returns exactly one result per request through the input
// register and the result register. The request is registered together with the map
// read, which is issued at the accepting edge on the memory's single read port; the
// step logic then updates the pose and writes the map's single write port as the
// result is registered. After reset the map is swept to unknown, one cell per cycle,
// through all GRID_SIZE*GRID_SIZE cells; requests are held off until the sweep ends,
// while threshold writes are taken at any time. Write the threshold only while idle.
module grid_pose_and_occupancy_tracker #(
	parameter int GRID_SIZE = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	gpot_cmd_if.sink   cmds,
	gpot_res_if.source results,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata
);
	localparam int PW = $clog2(GRID_SIZE);
	localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
	localparam logic [AW-1:0] GRID_W = AW'(GRID_SIZE);

	logic              map_busy;
	logic              accept;
	logic              go;
	logic              q_in_grid;
	logic [AW-1:0]     rd_addr;
	logic [1:0]        rd_cell;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [1:0]        wr_data;
	gpot_pkg::result_t step_res;

	logic              valid_s1;
	gpot_pkg::item_t   item_s1;
	logic              in_grid_s1;
	logic              res_valid_q;
	gpot_pkg::result_t res_q;

	// Advance the request when the result register is free or being drained.
	assign go          = valid_s1 && (!res_valid_q || results.ready);
	assign cmds.ready  = !map_busy && (!valid_s1 || go);
	assign accept      = cmds.valid && cmds.ready;

	assign q_in_grid = !cmds.query_x[7] && (cmds.query_x[6:0] < 7'(GRID_SIZE))
		&& !cmds.query_y[7] && (cmds.query_y[6:0] < 7'(GRID_SIZE));
	assign rd_addr = AW'(cmds.query_x[PW-1:0]) * GRID_W + AW'(cmds.query_y[PW-1:0]);

	gpot_map #(
		.GRID_SIZE(GRID_SIZE)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (map_busy),
		.rd_en   (accept && q_in_grid
			&& (gpot_pkg::cmd_t'(cmds.cmd) == gpot_pkg::CMD_READ)),
		.rd_addr (rd_addr),
		.rd_data (rd_cell),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	gpot_pose #(
		.GRID_SIZE(GRID_SIZE)
	) u_pose (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.go        (go),
		.item      (item_s1),
		.q_in_grid (in_grid_s1),
		.rd_cell   (rd_cell),
		.res       (step_res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd            <= cmds.cmd;
			item_s1.target_heading <= cmds.target_heading;
			item_s1.distance_cm    <= cmds.distance_cm;
			item_s1.query_x        <= cmds.query_x;
			item_s1.query_y        <= cmds.query_y;
			in_grid_s1             <= q_in_grid;
		end
		if (go) begin
			res_q <= step_res;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.turn_kind   = res_q.turn_kind;
	assign results.moved       = res_q.moved;
	assign results.obstacle    = res_q.obstacle;
	assign results.cell_value  = res_q.cell_value;
	assign results.cur_x       = res_q.cur_x;
	assign results.cur_y       = res_q.cur_y;
	assign results.cur_heading = res_q.cur_heading;

endmodule

// File: design/gpot_checker.sv
// Port-level checks on the tracker's result channel, bound to the top level.
// Depends on the top level's ports only.
module gpot_checker #(
	parameter int GRID_SIZE = 8
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] turn_kind,
	input logic       moved,
	input logic       obstacle,
	input logic [1:0] cell_value,
	input logic [5:0] cur_x,
	input logic [5:0] cur_y
);

	// Hold a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
	else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (7'(cur_x) < 7'(GRID_SIZE)) && (7'(cur_y) < 7'(GRID_SIZE)))
	else $error("position left the grid");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && moved |-> turn_kind == 2'd0 && !obstacle && cell_value == 2'd0)
	else $error("move result carries fields of another command");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && turn_kind != 2'd0 |-> !moved && !obstacle && cell_value == 2'd0)
	else $error("turn result carries fields of another command");

endmodule

bind grid_pose_and_occupancy_tracker gpot_checker #(
	.GRID_SIZE(GRID_SIZE)
) u_gpot_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.turn_kind  (results.turn_kind),
	.moved      (results.moved),
	.obstacle   (results.obstacle),
	.cell_value (results.cell_value),
	.cur_x      (results.cur_x),
	.cur_y      (results.cur_y)
);
